FILE: sv/rfae_pkg.sv
// Package for the register file ALU executor: opcodes, queue entry type and
// shared constants. No dependencies.
package rfae_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 5;
  localparam int MODE_W = 4;

  localparam logic [MODE_W-1:0] OP_LOAD = 4'd0;
  localparam logic [MODE_W-1:0] OP_OUT  = 4'd1;
  localparam logic [MODE_W-1:0] OP_MOV  = 4'd2;
  localparam logic [MODE_W-1:0] OP_XCHG = 4'd3;
  localparam logic [MODE_W-1:0] OP_ADD  = 4'd4;
  localparam logic [MODE_W-1:0] OP_SUB  = 4'd5;
  localparam logic [MODE_W-1:0] OP_MUL  = 4'd6;
  localparam logic [MODE_W-1:0] OP_DIV  = 4'd7;
  localparam logic [MODE_W-1:0] OP_MOD  = 4'd8;
  localparam logic [MODE_W-1:0] OP_AND  = 4'd9;
  localparam logic [MODE_W-1:0] OP_OR   = 4'd10;
  localparam logic [MODE_W-1:0] OP_XOR  = 4'd11;

  localparam logic STATUS_VALUE  = 1'b0;
  localparam logic STATUS_DIVZER = 1'b1;

  // Classified instruction held in the queue between front and back
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  src_x;
    logic [IDX_W-1:0]  src_y;
    logic [DATA_W-1:0] imm;
  } instr_t;

endpackage

FILE: sv/rfae_front.sv
// Front end: accepts input words, drops unused opcodes, resolves operand
// registers and pushes instructions into a two-entry queue. Uses rfae_pkg.
module rfae_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [55:0]     in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output rfae_pkg::instr_t q_data
);
  import rfae_pkg::*;

  instr_t           ent_r [2];
  instr_t           ent_nxt;
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic [MODE_W-1:0] mode;
  logic             three;
  logic             push, pop, useful;

  assign mode  = in_data[3:0];
  assign three = in_data[19];

  // Classify: pick the first operand by form
  always_comb begin
    ent_nxt.mode  = mode;
    ent_nxt.dest  = in_data[8:4];
    ent_nxt.src_y = in_data[18:14];
    ent_nxt.imm   = in_data[51:20];
    if (three && mode >= OP_ADD) begin
      ent_nxt.src_x = in_data[13:9];
    end else begin
      ent_nxt.src_x = in_data[8:4];
    end
  end

  assign useful   = (mode <= OP_XOR);
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && useful;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rp_r];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/rfae_divider.sv
// Iterative signed divider, one quotient bit per cycle, and shift-add
// multiplier sharing the same accumulator. Uses rfae_pkg.
module rfae_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       is_mul,
  input  logic [rfae_pkg::DATA_W-1:0] a,
  input  logic [rfae_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [rfae_pkg::DATA_W-1:0] quo,
  output logic [rfae_pkg::DATA_W-1:0] rem
);
  import rfae_pkg::*;

  logic              busy_r, mul_r, nq_r, nr_r;
  logic [5:0]        cnt_r;
  logic [DATA_W-1:0] q_r, r_r, d_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] r_sh;

  assign r_sh  = {r_r[DATA_W-2:0], q_r[DATA_W-1]};
  assign trial = {1'b0, r_sh} - {1'b0, d_r};
  assign done  = busy_r && (cnt_r == 6'd0);
  assign quo   = mul_r ? r_r : (nq_r ? (~q_r + 1'b1) : q_r);
  assign rem   = nr_r ? (~r_r + 1'b1) : r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  // Datapath: magnitudes for divide, raw operands for multiply
  always_ff @(posedge clk) begin
    if (start) begin
      mul_r <= is_mul;
      nq_r  <= a[DATA_W-1] ^ b[DATA_W-1];
      nr_r  <= a[DATA_W-1] & ~is_mul;
      if (is_mul) begin
        q_r <= a;
        d_r <= b;
      end else begin
        q_r <= a[DATA_W-1] ? (~a + 1'b1) : a;
        d_r <= b[DATA_W-1] ? (~b + 1'b1) : b;
      end
      r_r <= '0;
    end else if (busy_r && cnt_r != 6'd0) begin
      if (mul_r) begin
        // product low word: acc = acc + (d << i) for each set bit, lsb first
        q_r <= {1'b0, q_r[DATA_W-1:1]};
        d_r <= {d_r[DATA_W-2:0], 1'b0};
        if (q_r[0]) r_r <= r_r + d_r;
      end else begin
        if (!trial[DATA_W]) begin
          r_r <= trial[DATA_W-1:0];
          q_r <= {q_r[DATA_W-2:0], 1'b1};
        end else begin
          r_r <= r_sh;
          q_r <= {q_r[DATA_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: sv/rfae_back.sv
// Back end: register file, ALU and result register. Takes instructions
// from the front queue. Uses rfae_pkg and rfae_divider.
module rfae_back #(
  parameter int NUM_REGS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  rfae_pkg::instr_t            q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfae_pkg::DATA_W:0]   out_word
);
  import rfae_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;

  logic [DATA_W-1:0] rf_r [NUM_REGS];
  logic [1:0]        st_r;
  instr_t            cur_r;
  logic              ov_r;
  logic [DATA_W:0]   ow_r;
  logic [DATA_W-1:0] x, y, xd, res;
  logic              wr_en, wr2_en, take, dv_start, dv_done, slow;
  logic [DATA_W-1:0] dv_q, dv_r;
  logic [IDX_W-1:0]  wr_idx;
  logic [DATA_W-1:0] wr_val;

  function automatic logic [DATA_W-1:0] rd(input logic [DATA_W-1:0] f [NUM_REGS],
                                           input logic [IDX_W-1:0] i);
    logic [DATA_W-1:0] v;
    v = '0;
    if (32'(i) < NUM_REGS) v = f[i];
    return v;
  endfunction

  assign x  = rd(rf_r, q_data.src_x);
  assign y  = rd(rf_r, q_data.src_y);
  assign xd = rd(rf_r, q_data.dest);

  assign slow    = (q_data.mode == OP_MUL) ||
                   (((q_data.mode == OP_DIV) || (q_data.mode == OP_MOD)) && (y != '0));
  assign q_ready = (st_r == ST_IDLE) && !ov_r;
  assign take    = q_valid && q_ready;
  assign dv_start = take && slow;

  rfae_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .is_mul(q_data.mode == OP_MUL),
    .a(x), .b(y), .done(dv_done), .quo(dv_q), .rem(dv_r)
  );

  // Results of the operations that bypass the iterative unit, and write-back select
  always_comb begin
    res    = '0;
    wr_en  = 1'b0;
    wr2_en = 1'b0;
    wr_idx = q_data.dest;
    wr_val = '0;
    case (q_data.mode)
      OP_LOAD: begin wr_en = 1'b1; res = q_data.imm; end
      OP_MOV:  begin wr_en = 1'b1; res = y; end
      OP_XCHG: begin wr_en = 1'b1; wr2_en = 1'b1; res = y; end
      OP_ADD:  begin wr_en = 1'b1; res = x + y; end
      OP_SUB:  begin wr_en = 1'b1; res = x - y; end
      OP_AND:  begin wr_en = 1'b1; res = x & y; end
      OP_OR:   begin wr_en = 1'b1; res = x | y; end
      OP_XOR:  begin wr_en = 1'b1; res = x ^ y; end
      default: ;
    endcase
    if (st_r == ST_DIV && dv_done) begin
      wr_idx = cur_r.dest;
      wr_val = (cur_r.mode == OP_MOD) ? dv_r : dv_q;
    end else begin
      wr_val = res;
    end
  end

  // Register file, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else if (st_r == ST_DIV && dv_done) begin
      if (32'(wr_idx) < NUM_REGS) rf_r[wr_idx] <= wr_val;
    end else if (take && wr_en) begin
      if (32'(wr_idx) < NUM_REGS) rf_r[wr_idx] <= wr_val;
      if (wr2_en && 32'(q_data.src_y) < NUM_REGS) rf_r[q_data.src_y] <= xd;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (take) begin
            cur_r <= q_data;
            if (slow) begin
              st_r <= ST_DIV;
            end else if (q_data.mode == OP_OUT) begin
              ov_r <= 1'b1;
              ow_r <= {xd, STATUS_VALUE};
            end else if (q_data.mode == OP_DIV || q_data.mode == OP_MOD) begin
              ov_r <= 1'b1;
              ow_r <= {{DATA_W{1'b0}}, STATUS_DIVZER};
            end
          end
        end
        ST_DIV: if (dv_done) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

FILE: sv/register_file_alu_executor_unit.sv
// Top level of the register file ALU executor: front queue plus back end.
// Uses rfae_pkg, rfae_front, rfae_back.
//
//  channel | tdata fields (lsb up)                                  | dir
//  in_     | mode4 dest5 src_a5 src_b5 three1 immediate32 pad4        | in
//  out_    | status1 value32 pad7                                     | out
//
// Move, exchange, load, add, subtract and the logic operations bypass the
// iterative unit; multiply and divide/modulo by a nonzero divisor run in the shared
// iterative unit. The output register blocks the back end while a result waits;
// the two-word queue lets the front accept until it is full. Reset clears the register file.
module register_file_alu_executor_unit #(
  parameter int NUM_REGS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // mode, dest_index, src_a_index, src_b_index,
                                  // three_operand, immediate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, value
);
  import rfae_pkg::*;

  logic   q_valid, q_ready;
  instr_t q_data;
  logic [DATA_W:0] ow;

  rfae_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data(in_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  rfae_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_data(q_data), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(ow)
  );

  assign out_tdata = {7'd0, ow};

endmodule

FILE: sv/rfae_checker.sv
// Port-level checks for the executor; bound to the top level.
// Uses only the top-level ports.
module rfae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // error result always carries zero value
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[32:1] == 32'd0)
    else $error("error word with nonzero value");

  // padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("padding bits set");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind register_file_alu_executor_unit rfae_checker u_chk (.*);
